// ===== design/hgcp_pkg.sv =====
`default_nettype none

package hgcp_pkg;

  // input word kinds (in_tuser)
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_OPEN  = 2'd2;
  localparam logic [1:0] REQ_CLOSE = 2'd3;

  // output word kinds (out_tuser)
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_OFF  = 2'd1;
  localparam logic [1:0] CMD_ON   = 2'd2;
  localparam logic [1:0] CMD_SAVE = 2'd3;

  // key matcher hits
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_OFF  = 2'd1;
  localparam logic [1:0] HIT_ON   = 2'd2;
  localparam logic [1:0] HIT_TEXT = 2'd3;

  // percent escape phases
  localparam logic [1:0] PCT_IDLE = 2'd0;
  localparam logic [1:0] PCT_HIGH = 2'd1;
  localparam logic [1:0] PCT_LOW  = 2'd2;

  // matcher positions
  localparam logic [4:0] POS_PREFIX_END = 5'd9;   // after "GET /set?"
  localparam logic [4:0] POS_OFF_O      = 5'd10;
  localparam logic [4:0] POS_OFF_F      = 5'd11;
  localparam logic [4:0] POS_OFF_FF     = 5'd12;
  localparam logic [4:0] POS_ON_N       = 5'd13;
  localparam logic [4:0] POS_TEXT_T     = 5'd14;
  localparam logic [4:0] POS_LAST       = 5'd21;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_G       = 8'h47;

  typedef struct packed {
    logic [4:0] pos;
    logic [1:0] hit;
  } match_t;

  function automatic logic [7:0] key_prefix(input logic [3:0] idx);
    logic [7:0] c;
    begin
      unique case (idx)
        4'd0:    c = "G";
        4'd1:    c = "E";
        4'd2:    c = "T";
        4'd3:    c = " ";
        4'd4:    c = "/";
        4'd5:    c = "s";
        4'd6:    c = "e";
        4'd7:    c = "t";
        4'd8:    c = "?";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // "extarea=" after the 't'
  function automatic logic [7:0] key_text_tail(input logic [2:0] idx);
    logic [7:0] c;
    begin
      unique case (idx)
        3'd0: c = "e";
        3'd1: c = "x";
        3'd2: c = "t";
        3'd3: c = "a";
        3'd4: c = "r";
        3'd5: c = "e";
        3'd6: c = "a";
        3'd7: c = "=";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    begin
      v = 4'd0;
      if (c >= "0" && c <= "9") v = 4'(c - 8'h30);
      else if (c >= "a" && c <= "f") v = 4'(c - 8'h57);
      else if (c >= "A" && c <= "F") v = 4'(c - 8'h37);
      return v;
    end
  endfunction

  function automatic match_t match_step(input logic [4:0] p, input logic [7:0] b);
    match_t     m;
    logic       ok;
    logic [4:0] nxt;
    logic [4:0] tail_idx;
    begin
      ok       = 1'b0;
      nxt      = 5'd0;
      m.hit    = HIT_NONE;
      tail_idx = p - POS_TEXT_T;
      if (p < POS_PREFIX_END) begin
        if (b == key_prefix(p[3:0])) begin
          ok  = 1'b1;
          nxt = p + 5'd1;
        end
      end else if (p == POS_PREFIX_END) begin
        if (b == "O") begin
          ok = 1'b1; nxt = POS_OFF_O;
        end else if (b == "t") begin
          ok = 1'b1; nxt = POS_TEXT_T;
        end
      end else if (p == POS_OFF_O) begin
        if (b == "F") begin
          ok = 1'b1; nxt = POS_OFF_F;
        end else if (b == "N") begin
          ok = 1'b1; nxt = POS_ON_N;
        end
      end else if (p == POS_OFF_F) begin
        if (b == "F") begin
          ok = 1'b1; nxt = POS_OFF_FF;
        end
      end else if (p == POS_OFF_FF) begin
        if (b == "=") begin
          ok = 1'b1; m.hit = HIT_OFF;
        end
      end else if (p == POS_ON_N) begin
        if (b == "=") begin
          ok = 1'b1; m.hit = HIT_ON;
        end
      end else if (p >= POS_TEXT_T && p <= POS_LAST) begin
        if (b == key_text_tail(tail_idx[2:0])) begin
          ok = 1'b1;
          if (p == POS_LAST) m.hit = HIT_TEXT;
          else nxt = p + 5'd1;
        end
      end
      // mismatch: restart, a 'G' may begin a new key
      if (!ok) nxt = (b == CH_G) ? 5'd1 : 5'd0;
      m.pos = nxt;
      return m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/http_get_command_parser.sv =====
`default_nettype none
// A result word is registered and presented on out_* the cycle after its input word is taken.
// Throughput: one input word per cycle; in_tready drops only while a result waits
//   in the output register and out_tready is low.
// Reset (rst_n low, synchronous): connection closed, all parse state cleared,
//   output register empty, timeout_ms back to 5000.

module http_get_command_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // timeout_ms
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,    // [1:0] req_type
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [7:0] text_byte, [9:8] command, [15:10] zero
  output logic [1:0]       out_tuser    // [1:0] out_kind
);

  // ---------------- state ----------------
  logic [15:0] timeout_r;
  logic        conn_active_r, conn_active_nxt;
  logic        header_done_r, header_done_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [4:0]  match_pos_r, match_pos_nxt;
  logic        seen_off_r, seen_off_nxt;
  logic        seen_on_r, seen_on_nxt;
  logic        seen_text_r, seen_text_nxt;
  logic        text_active_r, text_active_nxt;
  logic [1:0]  pct_r, pct_nxt;
  logic [3:0]  high_nib_r, high_nib_nxt;
  logic        line_chars_r, line_chars_nxt;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [1:0]  out_cmd_r, out_cmd_nxt;
  logic        produce;

  logic        in_accept;
  logic [7:0]  b;
  logic [15:0] elapsed_inc;
  hgcp_pkg::match_t m;

  // The output register frees up in the same cycle it is drained, so a
  // stream with out_tready held high runs at one word per cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign b         = in_tdata;

  assign elapsed_inc = (elapsed_r == hgcp_pkg::ELAPSED_MAX) ? elapsed_r
                                                            : elapsed_r + 16'd1;
  assign m = hgcp_pkg::match_step(match_pos_r, b);

  // ---------------- next-state logic ----------------
  always_comb begin
    conn_active_nxt = conn_active_r;
    header_done_nxt = header_done_r;
    elapsed_nxt     = elapsed_r;
    match_pos_nxt   = match_pos_r;
    seen_off_nxt    = seen_off_r;
    seen_on_nxt     = seen_on_r;
    seen_text_nxt   = seen_text_r;
    text_active_nxt = text_active_r;
    pct_nxt         = pct_r;
    high_nib_nxt    = high_nib_r;
    line_chars_nxt  = line_chars_r;
    produce         = 1'b0;
    out_kind_nxt    = hgcp_pkg::KIND_TEXT;
    out_byte_nxt    = 8'd0;
    out_cmd_nxt     = hgcp_pkg::CMD_NONE;

    if (in_tuser == hgcp_pkg::REQ_OPEN || in_tuser == hgcp_pkg::REQ_CLOSE) begin
      // drop the request; open starts a fresh one
      conn_active_nxt = (in_tuser == hgcp_pkg::REQ_OPEN);
      header_done_nxt = 1'b0;
      elapsed_nxt     = 16'd0;
      match_pos_nxt   = 5'd0;
      seen_off_nxt    = 1'b0;
      seen_on_nxt     = 1'b0;
      seen_text_nxt   = 1'b0;
      text_active_nxt = 1'b0;
      pct_nxt         = hgcp_pkg::PCT_IDLE;
      high_nib_nxt    = 4'd0;
      line_chars_nxt  = 1'b0;
    end else if (conn_active_r && !header_done_r) begin
      if (in_tuser == hgcp_pkg::REQ_TICK) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > timeout_r) begin
          conn_active_nxt = 1'b0;
          elapsed_nxt     = 16'd0;
          match_pos_nxt   = 5'd0;
          seen_off_nxt    = 1'b0;
          seen_on_nxt     = 1'b0;
          seen_text_nxt   = 1'b0;
          text_active_nxt = 1'b0;
          pct_nxt         = hgcp_pkg::PCT_IDLE;
          high_nib_nxt    = 4'd0;
          line_chars_nxt  = 1'b0;
          produce         = 1'b1;
          out_kind_nxt    = hgcp_pkg::KIND_ABORT;
        end
      end else if (b == hgcp_pkg::CH_LF && !line_chars_r) begin
        // empty line: header end, command by priority
        header_done_nxt = 1'b1;
        text_active_nxt = 1'b0;
        pct_nxt         = hgcp_pkg::PCT_IDLE;
        produce         = 1'b1;
        out_kind_nxt    = hgcp_pkg::KIND_CMD;
        if (seen_off_r) out_cmd_nxt = hgcp_pkg::CMD_OFF;
        else if (seen_on_r) out_cmd_nxt = hgcp_pkg::CMD_ON;
        else if (seen_text_r) out_cmd_nxt = hgcp_pkg::CMD_SAVE;
      end else begin
        if (b == hgcp_pkg::CH_LF) line_chars_nxt = 1'b0;
        else if (b != hgcp_pkg::CH_CR) line_chars_nxt = 1'b1;

        match_pos_nxt = m.pos;
        if (m.hit == hgcp_pkg::HIT_OFF) seen_off_nxt = 1'b1;
        if (m.hit == hgcp_pkg::HIT_ON) seen_on_nxt = 1'b1;

        if (text_active_r) begin
          // URL decode
          if (b == hgcp_pkg::CH_SPACE) begin
            // end of text; a pending escape goes out with missing digits as 0
            if (pct_r == hgcp_pkg::PCT_HIGH) begin
              produce = 1'b1;
            end else if (pct_r == hgcp_pkg::PCT_LOW) begin
              produce      = 1'b1;
              out_byte_nxt = {high_nib_r, 4'd0};
            end
            text_active_nxt = 1'b0;
            pct_nxt         = hgcp_pkg::PCT_IDLE;
          end else if (pct_r == hgcp_pkg::PCT_HIGH) begin
            high_nib_nxt = hgcp_pkg::hex_val(b);
            pct_nxt      = hgcp_pkg::PCT_LOW;
          end else if (pct_r == hgcp_pkg::PCT_LOW) begin
            produce      = 1'b1;
            out_byte_nxt = {high_nib_r, hgcp_pkg::hex_val(b)};
            pct_nxt      = hgcp_pkg::PCT_IDLE;
          end else if (b == hgcp_pkg::CH_PERCENT) begin
            pct_nxt = hgcp_pkg::PCT_HIGH;
          end else begin
            produce      = 1'b1;
            out_byte_nxt = (b == hgcp_pkg::CH_PLUS) ? hgcp_pkg::CH_SPACE : b;
          end
        end else if (m.hit == hgcp_pkg::HIT_TEXT && !seen_text_r) begin
          // first textarea key opens the text
          seen_text_nxt   = 1'b1;
          text_active_nxt = 1'b1;
          pct_nxt         = hgcp_pkg::PCT_IDLE;
        end
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= hgcp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_active_r <= 1'b0;
      header_done_r <= 1'b0;
      elapsed_r     <= 16'd0;
      match_pos_r   <= 5'd0;
      seen_off_r    <= 1'b0;
      seen_on_r     <= 1'b0;
      seen_text_r   <= 1'b0;
      text_active_r <= 1'b0;
      pct_r         <= hgcp_pkg::PCT_IDLE;
      high_nib_r    <= 4'd0;
      line_chars_r  <= 1'b0;
    end else if (in_accept) begin
      conn_active_r <= conn_active_nxt;
      header_done_r <= header_done_nxt;
      elapsed_r     <= elapsed_nxt;
      match_pos_r   <= match_pos_nxt;
      seen_off_r    <= seen_off_nxt;
      seen_on_r     <= seen_on_nxt;
      seen_text_r   <= seen_text_nxt;
      text_active_r <= text_active_nxt;
      pct_r         <= pct_nxt;
      high_nib_r    <= high_nib_nxt;
      line_chars_r  <= line_chars_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && produce) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_cmd_r  <= out_cmd_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_cmd_r, out_byte_r};

  // ---------------- assertions ----------------
  a_done_needs_conn: assert property (@(posedge clk) disable iff (!rst_n)
    header_done_r |-> conn_active_r)
    else $error("header done without open connection");

  a_text_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    text_active_r |-> seen_text_r)
    else $error("text active before textarea key");

  a_pct_idle_outside_text: assert property (@(posedge clk) disable iff (!rst_n)
    !text_active_r |-> (pct_r == hgcp_pkg::PCT_IDLE))
    else $error("escape pending outside text");

  a_match_range: assert property (@(posedge clk) disable iff (!rst_n)
    match_pos_r <= hgcp_pkg::POS_LAST)
    else $error("matcher position out of range");

  a_abort_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && produce && out_kind_nxt == hgcp_pkg::KIND_ABORT) |=> !conn_active_r)
    else $error("abort left connection open");

endmodule

`default_nettype wire
